>>> rtl/sma_pkg.sv
// Shared types and codes for the stack machine ALU.
package sma_pkg;

   // command codes
   localparam logic [4:0] CMD_PUSH  = 5'd0;
   localparam logic [4:0] CMD_ADD   = 5'd1;
   localparam logic [4:0] CMD_SUB   = 5'd2;
   localparam logic [4:0] CMD_MUL   = 5'd3;
   localparam logic [4:0] CMD_DIV   = 5'd4;
   localparam logic [4:0] CMD_MOD   = 5'd5;
   localparam logic [4:0] CMD_DUP   = 5'd6;
   localparam logic [4:0] CMD_POP   = 5'd7;
   localparam logic [4:0] CMD_EQ    = 5'd8;
   localparam logic [4:0] CMD_NE    = 5'd9;
   localparam logic [4:0] CMD_LT    = 5'd10;
   localparam logic [4:0] CMD_GT    = 5'd11;
   localparam logic [4:0] CMD_LE    = 5'd12;
   localparam logic [4:0] CMD_GE    = 5'd13;
   localparam logic [4:0] CMD_EXCH  = 5'd14;
   localparam logic [4:0] CMD_INDEX = 5'd15;
   localparam logic [4:0] CMD_JMP   = 5'd16;
   localparam logic [4:0] CMD_JNIF  = 5'd17;

   // result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_UNDER = 3'd1;
   localparam logic [2:0] ST_OVER  = 3'd2;
   localparam logic [2:0] ST_DIVZ  = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   // read address select
   localparam logic [1:0] RD_N1  = 2'd0;
   localparam logic [1:0] RD_N2  = 2'd1;
   localparam logic [1:0] RD_N3  = 2'd2;
   localparam logic [1:0] RD_IDX = 2'd3;

   // write address select
   localparam logic [1:0] WA_N0 = 2'd0;
   localparam logic [1:0] WA_N1 = 2'd1;
   localparam logic [1:0] WA_N2 = 2'd2;

   // write data select
   localparam logic [2:0] WD_LIT = 3'd0;
   localparam logic [2:0] WD_B   = 3'd1;
   localparam logic [2:0] WD_A   = 3'd2;
   localparam logic [2:0] WD_ALU = 3'd3;
   localparam logic [2:0] WD_MD  = 3'd4;
   localparam logic [2:0] WD_RD  = 3'd5;

   // top-of-stack select
   localparam logic [2:0] TS_LIT = 3'd0;
   localparam logic [2:0] TS_B0  = 3'd1;
   localparam logic [2:0] TS_A0  = 3'd2;
   localparam logic [2:0] TS_ALU = 3'd3;
   localparam logic [2:0] TS_MD  = 3'd4;
   localparam logic [2:0] TS_RD  = 3'd5;
   localparam logic [2:0] TS_RD0 = 3'd6;

   // stack count update
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC1 = 2'd2;
   localparam logic [1:0] CNT_DEC2 = 2'd3;

   typedef struct packed {
      logic [4:0]         cmd;
      logic signed [31:0] literal;
   } sma_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] top_value;
      logic [6:0]         stack_level;
      logic               branch_taken;
      logic signed [31:0] branch_offset;
   } sma_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       req_load;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       ld_b;
      logic       ld_a;
      logic       wr_en;
      logic [1:0] wr_addr_sel;
      logic [2:0] wr_data_sel;
      logic [1:0] cnt_op;
      logic       md_start;
      logic       flags_load;
      logic [2:0] status;
      logic       taken;
      logic       top_load;
      logic [2:0] top_sel;
      logic       rsp_load;
   } sma_ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [4:0] cmd;
      logic       n_ge1;
      logic       n_ge2;
      logic       n_full;
      logic       b_zero;
      logic       a_zero;
      logic       idx_ok;
      logic       md_done;
      logic       rsp_busy;
   } sma_sts_type;

endpackage

>>> rtl/sma_muldiv.sv
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
module sma_muldiv #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  is_mul,
   input  logic                  is_mod,
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int DW   = DATA_WIDTH;
   localparam int CNTW = $clog2(DW);

   logic [DW-1:0]   x_ff, y_ff, acc_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff, done_ff, mul_ff, mod_ff, negq_ff, negr_ff;
   logic [DW-1:0]   mag_a, mag_b;
   logic [DW:0]     trial, diff;

   assign mag_a = op_a[DW-1] ? ({DW{1'b0}} - op_a) : op_a;
   assign mag_b = op_b[DW-1] ? ({DW{1'b0}} - op_b) : op_b;
   assign trial = {acc_ff, y_ff[DW-1]};
   assign diff  = trial - {1'b0, x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mul_ff  <= is_mul;
         mod_ff  <= is_mod;
         negq_ff <= op_a[DW-1] ^ op_b[DW-1];
         negr_ff <= op_a[DW-1];
         acc_ff  <= '0;
         x_ff    <= is_mul ? op_a : mag_b;
         y_ff    <= is_mul ? op_b : mag_a;
      end else if (busy_ff) begin
         if (mul_ff) begin
            if (y_ff[0]) begin
               acc_ff <= acc_ff + x_ff;
            end
            x_ff <= {x_ff[DW-2:0], 1'b0};
            y_ff <= {1'b0, y_ff[DW-1:1]};
         end else begin
            // borrow clear means the divisor fits
            if (!diff[DW]) begin
               acc_ff <= diff[DW-1:0];
            end else begin
               acc_ff <= trial[DW-1:0];
            end
            y_ff <= {y_ff[DW-2:0], !diff[DW]};
         end
      end
   end

   assign done = done_ff;

   always_comb begin
      if (mul_ff) begin
         result = acc_ff;
      end else if (mod_ff) begin
         result = negr_ff ? ({DW{1'b0}} - acc_ff) : acc_ff;
      end else begin
         result = negq_ff ? ({DW{1'b0}} - y_ff) : y_ff;
      end
   end

endmodule

>>> rtl/sma_datapath.sv
// Datapath: stack memory, operand and result registers, ALU, response register.
module sma_datapath #(
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sma_pkg::sma_req_type req_payload,
   input  sma_pkg::sma_ctl_type ctl,
   output sma_pkg::sma_sts_type sts,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output sma_pkg::sma_rsp_type rsp_payload
);

   localparam int DW   = DATA_WIDTH;
   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam int CMPW = (DW > CW) ? DW : CW;

   logic [DW-1:0] mem [STACK_DEPTH];

   logic [4:0]          cmd_ff;
   logic [DW-1:0]       lit_ff, b_ff, a_ff, rdata_ff, top_ff, offset_ff;
   logic [CW-1:0]       cnt_ff;
   logic [2:0]          status_ff;
   logic                taken_ff;
   logic                rsp_valid_ff;
   sma_pkg::sma_rsp_type rsp_ff;

   logic signed [63:0] lit_ext;
   logic [CMPW-1:0]    cmp_cnt, cmp_b, n1, n2, n3, nidx;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [DW-1:0]      wr_data, alu_res, md_res, top_in;
   logic               md_done;
   logic [63:0]        top_wide, off_wide;

   assign lit_ext = 64'(req_payload.literal);
   assign cmp_cnt = CMPW'(cnt_ff);
   assign cmp_b   = CMPW'(b_ff);
   assign n1      = cmp_cnt - CMPW'(1);
   assign n2      = cmp_cnt - CMPW'(2);
   assign n3      = cmp_cnt - CMPW'(3);
   assign nidx    = n2 - cmp_b;

   always_comb begin
      case (ctl.rd_sel)
         sma_pkg::RD_N1: rd_addr = n1[AW-1:0];
         sma_pkg::RD_N2: rd_addr = n2[AW-1:0];
         sma_pkg::RD_N3: rd_addr = n3[AW-1:0];
         default:        rd_addr = nidx[AW-1:0];
      endcase
   end

   always_comb begin
      case (ctl.wr_addr_sel)
         sma_pkg::WA_N0: wr_addr = cmp_cnt[AW-1:0];
         sma_pkg::WA_N1: wr_addr = n1[AW-1:0];
         default:        wr_addr = n2[AW-1:0];
      endcase
   end

   always_comb begin
      case (cmd_ff)
         sma_pkg::CMD_ADD: alu_res = a_ff + b_ff;
         sma_pkg::CMD_SUB: alu_res = a_ff - b_ff;
         sma_pkg::CMD_EQ:  alu_res = DW'(a_ff == b_ff);
         sma_pkg::CMD_NE:  alu_res = DW'(a_ff != b_ff);
         sma_pkg::CMD_LT:  alu_res = DW'($signed(a_ff) < $signed(b_ff));
         sma_pkg::CMD_GT:  alu_res = DW'($signed(b_ff) < $signed(a_ff));
         sma_pkg::CMD_LE:  alu_res = DW'(!($signed(b_ff) < $signed(a_ff)));
         sma_pkg::CMD_GE:  alu_res = DW'(!($signed(a_ff) < $signed(b_ff)));
         default:          alu_res = '0;
      endcase
   end

   always_comb begin
      case (ctl.wr_data_sel)
         sma_pkg::WD_LIT: wr_data = lit_ff;
         sma_pkg::WD_B:   wr_data = b_ff;
         sma_pkg::WD_A:   wr_data = a_ff;
         sma_pkg::WD_ALU: wr_data = alu_res;
         sma_pkg::WD_MD:  wr_data = md_res;
         default:         wr_data = rdata_ff;
      endcase
   end

   always_comb begin
      case (ctl.top_sel)
         sma_pkg::TS_LIT: top_in = lit_ff;
         sma_pkg::TS_B0:  top_in = (cnt_ff != '0) ? b_ff : '0;
         sma_pkg::TS_A0:  top_in = (cnt_ff >= CW'(2)) ? a_ff : '0;
         sma_pkg::TS_ALU: top_in = alu_res;
         sma_pkg::TS_MD:  top_in = md_res;
         sma_pkg::TS_RD:  top_in = rdata_ff;
         sma_pkg::TS_RD0: top_in = (cnt_ff != '0) ? rdata_ff : '0;
         default:         top_in = '0;
      endcase
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   sma_muldiv #(
      .DATA_WIDTH(DW)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.md_start),
      .is_mul (cmd_ff == sma_pkg::CMD_MUL),
      .is_mod (cmd_ff == sma_pkg::CMD_MOD),
      .op_a   (a_ff),
      .op_b   (b_ff),
      .done   (md_done),
      .result (md_res)
   );

   always_ff @(posedge clock) begin
      if (ctl.req_load) begin
         cmd_ff <= req_payload.cmd;
         lit_ff <= lit_ext[DW-1:0];
      end
      if (ctl.ld_b) begin
         b_ff <= rdata_ff;
      end
      if (ctl.ld_a) begin
         a_ff <= rdata_ff;
      end
      if (ctl.flags_load) begin
         status_ff <= ctl.status;
         taken_ff  <= ctl.taken;
         offset_ff <= ctl.taken ? b_ff : '0;
      end
      if (ctl.top_load) begin
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case (ctl.cnt_op)
            sma_pkg::CNT_INC:  cnt_ff <= cnt_ff + CW'(1);
            sma_pkg::CNT_DEC1: cnt_ff <= cnt_ff - CW'(1);
            sma_pkg::CNT_DEC2: cnt_ff <= cnt_ff - CW'(2);
            default:           cnt_ff <= cnt_ff;
         endcase
      end
   end

   assign top_wide = 64'(top_ff);
   assign off_wide = 64'(offset_ff);

   // output register frees the core while a beat waits downstream
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.rsp_load) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.top_value     <= top_wide[31:0];
         rsp_ff.stack_level   <= 7'(cnt_ff);
         rsp_ff.branch_taken  <= taken_ff;
         rsp_ff.branch_offset <= off_wide[31:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.cmd      = cmd_ff;
   assign sts.n_ge1    = (cnt_ff != '0);
   assign sts.n_ge2    = (cnt_ff >= CW'(2));
   assign sts.n_full   = (cnt_ff >= CW'(STACK_DEPTH));
   assign sts.b_zero   = (b_ff == '0);
   assign sts.a_zero   = (a_ff == '0);
   assign sts.idx_ok   = !b_ff[DW-1] && (cmp_b < n1);
   assign sts.md_done  = md_done;
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

endmodule

>>> rtl/sma_ctrl.sv
// Controller state machine: sequences reads, execution and writeback per command.
module sma_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sma_pkg::sma_sts_type sts,
   output sma_pkg::sma_ctl_type ctl
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDB  = 4'd1;
   localparam logic [3:0] S_RDA  = 4'd2;
   localparam logic [3:0] S_LDA  = 4'd3;
   localparam logic [3:0] S_EXEC = 4'd4;
   localparam logic [3:0] S_MD   = 4'd5;
   localparam logic [3:0] S_EXCH = 4'd6;
   localparam logic [3:0] S_IDXW = 4'd7;
   localparam logic [3:0] S_TOPR = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.req_load = 1'b1;
               state_in     = S_RDB;
            end
         end
         S_RDB: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = sma_pkg::RD_N1;
            state_in   = S_RDA;
         end
         S_RDA: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = sma_pkg::RD_N2;
            ctl.ld_b   = 1'b1;
            state_in   = S_LDA;
         end
         S_LDA: begin
            ctl.ld_a = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // flags always settle here; top defaults to the unchanged stack
            ctl.flags_load = 1'b1;
            ctl.status     = sma_pkg::ST_OK;
            ctl.top_load   = 1'b1;
            ctl.top_sel    = sma_pkg::TS_B0;
            state_in       = S_OUT;
            case (sts.cmd)
               sma_pkg::CMD_PUSH: begin
                  if (sts.n_full) begin
                     ctl.status = sma_pkg::ST_OVER;
                  end else begin
                     ctl.wr_en       = 1'b1;
                     ctl.wr_addr_sel = sma_pkg::WA_N0;
                     ctl.wr_data_sel = sma_pkg::WD_LIT;
                     ctl.cnt_op      = sma_pkg::CNT_INC;
                     ctl.top_sel     = sma_pkg::TS_LIT;
                  end
               end
               sma_pkg::CMD_ADD, sma_pkg::CMD_SUB, sma_pkg::CMD_EQ, sma_pkg::CMD_NE,
               sma_pkg::CMD_LT, sma_pkg::CMD_GT, sma_pkg::CMD_LE, sma_pkg::CMD_GE: begin
                  if (!sts.n_ge2) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else begin
                     ctl.wr_en       = 1'b1;
                     ctl.wr_addr_sel = sma_pkg::WA_N2;
                     ctl.wr_data_sel = sma_pkg::WD_ALU;
                     ctl.cnt_op      = sma_pkg::CNT_DEC1;
                     ctl.top_sel     = sma_pkg::TS_ALU;
                  end
               end
               sma_pkg::CMD_MUL, sma_pkg::CMD_DIV, sma_pkg::CMD_MOD: begin
                  if (!sts.n_ge2) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else if (sts.cmd != sma_pkg::CMD_MUL && sts.b_zero) begin
                     ctl.status = sma_pkg::ST_DIVZ;
                  end else begin
                     ctl.md_start = 1'b1;
                     ctl.top_load = 1'b0;
                     state_in     = S_MD;
                  end
               end
               sma_pkg::CMD_DUP: begin
                  if (!sts.n_ge1) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else if (sts.n_full) begin
                     ctl.status = sma_pkg::ST_OVER;
                  end else begin
                     ctl.wr_en       = 1'b1;
                     ctl.wr_addr_sel = sma_pkg::WA_N0;
                     ctl.wr_data_sel = sma_pkg::WD_B;
                     ctl.cnt_op      = sma_pkg::CNT_INC;
                  end
               end
               sma_pkg::CMD_POP: begin
                  if (!sts.n_ge1) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else begin
                     ctl.cnt_op  = sma_pkg::CNT_DEC1;
                     ctl.top_sel = sma_pkg::TS_A0;
                  end
               end
               sma_pkg::CMD_EXCH: begin
                  if (!sts.n_ge2) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else begin
                     ctl.wr_en       = 1'b1;
                     ctl.wr_addr_sel = sma_pkg::WA_N2;
                     ctl.wr_data_sel = sma_pkg::WD_B;
                     ctl.top_load    = 1'b0;
                     state_in        = S_EXCH;
                  end
               end
               sma_pkg::CMD_INDEX: begin
                  if (!sts.n_ge1) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else if (!sts.idx_ok) begin
                     ctl.status = sma_pkg::ST_RANGE;
                  end else begin
                     ctl.rd_en    = 1'b1;
                     ctl.rd_sel   = sma_pkg::RD_IDX;
                     ctl.top_load = 1'b0;
                     state_in     = S_IDXW;
                  end
               end
               sma_pkg::CMD_JMP: begin
                  if (!sts.n_ge1) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else begin
                     ctl.cnt_op  = sma_pkg::CNT_DEC1;
                     ctl.taken   = 1'b1;
                     ctl.top_sel = sma_pkg::TS_A0;
                  end
               end
               sma_pkg::CMD_JNIF: begin
                  if (!sts.n_ge2) begin
                     ctl.status = sma_pkg::ST_UNDER;
                  end else begin
                     // new top sits three below the old count
                     ctl.cnt_op   = sma_pkg::CNT_DEC2;
                     ctl.taken    = sts.a_zero;
                     ctl.rd_en    = 1'b1;
                     ctl.rd_sel   = sma_pkg::RD_N3;
                     ctl.top_load = 1'b0;
                     state_in     = S_TOPR;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MD: begin
            if (sts.md_done) begin
               ctl.wr_en       = 1'b1;
               ctl.wr_addr_sel = sma_pkg::WA_N2;
               ctl.wr_data_sel = sma_pkg::WD_MD;
               ctl.cnt_op      = sma_pkg::CNT_DEC1;
               ctl.top_load    = 1'b1;
               ctl.top_sel     = sma_pkg::TS_MD;
               state_in        = S_OUT;
            end
         end
         S_EXCH: begin
            ctl.wr_en       = 1'b1;
            ctl.wr_addr_sel = sma_pkg::WA_N1;
            ctl.wr_data_sel = sma_pkg::WD_A;
            ctl.top_load    = 1'b1;
            ctl.top_sel     = sma_pkg::TS_A0;
            state_in        = S_OUT;
         end
         S_IDXW: begin
            ctl.wr_en       = 1'b1;
            ctl.wr_addr_sel = sma_pkg::WA_N1;
            ctl.wr_data_sel = sma_pkg::WD_RD;
            ctl.top_load    = 1'b1;
            ctl.top_sel     = sma_pkg::TS_RD;
            state_in        = S_OUT;
         end
         S_TOPR: begin
            ctl.top_load = 1'b1;
            ctl.top_sel  = sma_pkg::TS_RD0;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (!sts.rsp_busy) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/stack_machine_alu_core.sv
// Top level of the stack machine ALU: controller plus datapath.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    sma_req_type  (cmd, literal)
//   rsp      out  rsp_valid/stall    sma_rsp_type  (status, top, level, branch)
//
// One command at a time. Each beat runs from accept through two stack reads
// through the registered memory port, execute and result before the next
// accept. exch, index and the conditional jump go through an extra state for
// the extra memory access; mul, div and mod wait on the bit-serial mul/div unit.
// Synchronous reset empties the stack; stack contents are not cleared.
// The result register lets a finished beat wait under rsp_stall while the
// next command is accepted; that command holds before its result is loaded.
module stack_machine_alu_core #(
   parameter int STACK_DEPTH = 64,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sma_pkg::sma_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sma_pkg::sma_rsp_type rsp_payload
);

   sma_pkg::sma_ctl_type ctl;
   sma_pkg::sma_sts_type sts;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   sma_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("core took a second beat while busy");

   a_no_branch_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != sma_pkg::ST_OK) |-> !rsp_payload.branch_taken)
      else $error("branch reported on failed command");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.branch_taken) |-> (rsp_payload.branch_offset == '0))
      else $error("offset nonzero without branch");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status <= sma_pkg::ST_RANGE))
      else $error("bad status code");

endmodule
